// ----- rtl/core/plc_pkg.sv -----
package plc_pkg;

	localparam int VW = 32;
	localparam int KCW = 5;
	localparam int DIV_STEPS = 33;
	localparam int DCW = 6;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_EVAL   = 2'd3
	} op_e;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_PICK,
		S_CLASS,
		S_MUL,
		S_DIV,
		S_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [VW-1:0] pos;
		logic signed [VW-1:0] st;
		logic signed [VW-1:0] et;
		logic signed [VW-1:0] sv;
		logic signed [VW-1:0] ev;
	} key_t;

	typedef struct packed {
		logic ins_en;
		logic rem_en;
	} cell_ctl_t;

endpackage

// ----- rtl/core/plc_cell.sv -----
module plc_cell (
	input  logic                       clk,
	input  plc_pkg::cell_ctl_t         ctl,
	input  logic                       valid,
	input  logic                       right_valid,
	input  logic                       rem_shift,
	input  logic                       left_le,
	input  plc_pkg::key_t              new_key,
	input  plc_pkg::key_t              left_key,
	input  plc_pkg::key_t              right_key,
	input  logic signed [31:0]         query,
	output plc_pkg::key_t              key,
	output logic                       le,
	output logic                       match
);
	import plc_pkg::*;

	key_t key_q;

	assign key = key_q;
	assign le = valid && (key_q.pos <= new_key.pos);
	assign match = valid && right_valid && (query >= key_q.pos) && (query < right_key.pos);

	// keys at or below the new position hold; the first one above takes it; the rest shift up
	always_ff @(posedge clk) begin
		if (ctl.ins_en && !le) begin
			key_q <= left_le ? new_key : left_key;
		end else if (ctl.rem_en && rem_shift) begin
			key_q <= right_key;
		end
	end

endmodule

// ----- rtl/core/piecewise_linear_curve_eval.sv -----
// Sorted key table of up to MAX_KEYS linear segments, one key per cell in a row of cells.
// Add, remove and clear update the whole row at once and go straight to the output
// state once the request is taken. An interpolating evaluate steps through match,
// segment select and classify, a 33x33 multiply, the 66/33-bit restoring divider
// at one quotient bit a cycle, then saturate and output. An evaluate that clamps to a
// segment end goes from classify straight to output, one on an empty table from match.
// One request is in flight at a time; a new request is taken while the last result waits.
module piecewise_linear_curve_eval #(
	parameter int MAX_KEYS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [31:0] position,
	input  logic signed [31:0] seg_start_t,
	input  logic signed [31:0] seg_end_t,
	input  logic signed [31:0] seg_start_v,
	input  logic signed [31:0] seg_end_v,
	input  logic [3:0]         key_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic [1:0]         status,
	output logic [4:0]         key_count
);
	import plc_pkg::*;

	localparam int NW = $clog2(MAX_KEYS + 1);
	localparam int IW = $clog2(MAX_KEYS);

	state_t state_q, state_d;
	logic [NW-1:0] n_q;
	logic [1:0] op_q;
	logic [1:0] status_q;
	logic signed [31:0] q_q;
	logic [MAX_KEYS-1:0] match_q;
	logic ge_q;
	key_t seg_q;
	logic [32:0] d_q, w_q, mag_q;
	logic neg_q;
	logic [32:0] rem_q, num_q, quo_q;
	logic [DCW-1:0] cnt_q;
	logic signed [31:0] res_q;
	logic out_valid_q;
	logic signed [31:0] value_q;
	logic [1:0] status_o_q;
	logic [KCW-1:0] count_o_q;

	logic accept;
	logic full;
	logic rem_ok;
	cell_ctl_t ctl;
	key_t new_key;
	key_t cell_key [MAX_KEYS];
	logic [MAX_KEYS-1:0] cell_le, cell_match, cell_valid;
	logic [IW-1:0] sel;
	logic [IW-1:0] last_idx;
	logic [33:0] rem_sh;
	logic [33:0] rem_sub;
	logic signed [34:0] sum;
	logic out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign full = (32'(n_q) >= MAX_KEYS);
	assign rem_ok = ({28'd0, key_index} < 32'(n_q));
	assign ctl.ins_en = accept && (operation == OP_ADD) && !full;
	assign ctl.rem_en = accept && (operation == OP_REMOVE) && rem_ok;
	assign new_key = '{pos: position, st: seg_start_t, et: seg_end_t,
		sv: seg_start_v, ev: seg_end_v};
	assign last_idx = IW'(n_q - NW'(1));
	assign out_free = !out_valid_q || out_ready;

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		assign cell_valid[i] = (32'(i) < 32'(n_q));
		plc_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (cell_valid[i]),
			.right_valid((i + 1 < MAX_KEYS) ? cell_valid[(i + 1) % MAX_KEYS] : 1'b0),
			.rem_shift  (32'(i) >= {28'd0, key_index}),
			.left_le    ((i == 0) ? 1'b1 : cell_le[(i + MAX_KEYS - 1) % MAX_KEYS]),
			.new_key    (new_key),
			.left_key   ((i == 0) ? new_key : cell_key[(i + MAX_KEYS - 1) % MAX_KEYS]),
			.right_key  ((i + 1 < MAX_KEYS) ? cell_key[(i + 1) % MAX_KEYS] : cell_key[i]),
			.query      (q_q),
			.key        (cell_key[i]),
			.le         (cell_le[i]),
			.match      (cell_match[i])
		);
	end

	// first matching interval, else last key if at or past it, else first key
	always_comb begin
		sel = '0;
		if (n_q != NW'(1)) begin
			if (ge_q) begin
				sel = last_idx;
			end
			for (int i = MAX_KEYS - 1; i >= 0; i--) begin
				if (match_q[i]) begin
					sel = IW'(i);
				end
			end
		end
	end

	assign rem_sh = {rem_q, num_q[32]};
	assign rem_sub = rem_sh - {1'b0, w_q};
	assign sum = neg_q ? (35'(seg_q.sv) - $signed({2'b00, quo_q}))
		: (35'(seg_q.sv) + $signed({2'b00, quo_q}));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = (operation == OP_EVAL) ? S_MATCH : S_DONE;
			S_MATCH: state_d = (n_q == '0) ? S_DONE : S_PICK;
			S_PICK:  state_d = S_CLASS;
			S_CLASS: state_d = ((q_q < seg_q.st) || (q_q >= seg_q.et)) ? S_DONE : S_MUL;
			S_MUL:   state_d = S_DIV;
			S_DIV:   if (cnt_q == DCW'(DIV_STEPS - 1)) state_d = S_FIN;
			S_FIN:   state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.ins_en) begin
				n_q <= n_q + NW'(1);
			end else if (ctl.rem_en) begin
				n_q <= n_q - NW'(1);
			end else if (accept && operation == OP_CLEAR) begin
				n_q <= '0;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			q_q <= position;
			res_q <= '0;
			if (operation == OP_ADD && full) begin
				status_q <= ST_FULL;
			end else if (operation == OP_REMOVE && !rem_ok) begin
				status_q <= ST_RANGE;
			end else begin
				status_q <= ST_OK;
			end
		end
		unique case (state_q)
			S_MATCH: begin
				match_q <= cell_match;
				ge_q <= (q_q >= cell_key[last_idx].pos);
			end
			S_PICK: seg_q <= cell_key[sel];
			S_CLASS: begin
				if (q_q < seg_q.st) begin
					res_q <= seg_q.sv;
				end else if (q_q >= seg_q.et) begin
					res_q <= seg_q.ev;
				end
				d_q <= 33'(q_q) - 33'(seg_q.st);
				w_q <= 33'(seg_q.et) - 33'(seg_q.st);
				neg_q <= (seg_q.ev < seg_q.sv);
				mag_q <= (seg_q.ev < seg_q.sv) ? (33'(seg_q.sv) - 33'(seg_q.ev))
					: (33'(seg_q.ev) - 33'(seg_q.sv));
			end
			S_MUL: begin
				{rem_q, num_q} <= {33'd0, mag_q} * {33'd0, d_q};
				cnt_q <= '0;
				quo_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_sub[33] ? rem_sh[32:0] : rem_sub[32:0];
				quo_q <= {quo_q[31:0], !rem_sub[33]};
				num_q <= {num_q[31:0], 1'b0};
				cnt_q <= cnt_q + DCW'(1);
			end
			S_FIN: begin
				if (sum > 35'sd2147483647) begin
					res_q <= 32'sh7fffffff;
				end else if (sum < -35'sd2147483648) begin
					res_q <= 32'sh80000000;
				end else begin
					res_q <= sum[31:0];
				end
			end
			S_DONE: begin
				if (out_free) begin
					value_q <= (op_q == OP_EVAL) ? res_q : '0;
					status_o_q <= status_q;
					count_o_q <= KCW'(n_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign status = status_o_q;
	assign key_count = count_o_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(n_q) <= MAX_KEYS) else $error("key count above table size");
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == OP_ADD && full |=> $stable(n_q))
		else $error("add to full table changed count");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < w_q) else $error("divider remainder not below divisor");
`endif

endmodule

// ----- sim/piecewise_linear_curve_eval_test.sv -----
module piecewise_linear_curve_eval_test;
	timeunit 1ns;
	timeprecision 1ps;
	import plc_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
		logic [4:0]         key_count;
	} curve_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         operation;
	logic signed [31:0] position;
	logic signed [31:0] seg_start_t;
	logic signed [31:0] seg_end_t;
	logic signed [31:0] seg_start_v;
	logic signed [31:0] seg_end_v;
	logic [3:0]         key_index;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] value;
	logic [1:0]         status;
	logic [4:0]         key_count;

	// shadow copy of the key table
	key_t        shadow_keys[TABLE_DEPTH];
	int          shadow_count;
	curve_result_t expected_results[$];
	int          error_count;
	int          idle_cycles;
	bit          hold_results;

	piecewise_linear_curve_eval #(.MAX_KEYS(TABLE_DEPTH)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic signed [31:0] segment_value(int k, logic signed [31:0] q);
		longint st, et, sv, ev, dv, r;
		logic [63:0] mag, span, offs, quo;
		st = shadow_keys[k].st;
		et = shadow_keys[k].et;
		sv = shadow_keys[k].sv;
		ev = shadow_keys[k].ev;
		if (longint'(q) < st)
			return sv[31:0];
		if (longint'(q) >= et)
			return ev[31:0];
		dv = ev - sv;
		mag = (dv < 0) ? -dv : dv;
		offs = longint'(q) - st;
		span = et - st;
		quo = (mag * offs) / span;
		r = (dv < 0) ? sv - longint'(quo) : sv + longint'(quo);
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic logic signed [31:0] curve_value(logic signed [31:0] q);
		if (shadow_count == 0)
			return '0;
		for (int i = 0; i + 1 < shadow_count; i++) begin
			if (q >= shadow_keys[i].pos && q < shadow_keys[i+1].pos)
				return segment_value(i, q);
		end
		if (q >= shadow_keys[shadow_count-1].pos)
			return segment_value(shadow_count - 1, q);
		return segment_value(0, q);
	endfunction

	function automatic curve_result_t apply_request(op_e op, key_t k, logic [3:0] idx);
		curve_result_t res;
		int at;
		res = '0;
		case (op)
			OP_ADD: begin
				if (shadow_count >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					at = 0;
					while (at < shadow_count && shadow_keys[at].pos <= k.pos)
						at++;
					for (int i = shadow_count; i > at; i--)
						shadow_keys[i] = shadow_keys[i-1];
					shadow_keys[at] = k;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				if (idx >= shadow_count) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = idx; i + 1 < shadow_count; i++)
						shadow_keys[i] = shadow_keys[i+1];
					shadow_count--;
				end
			end
			OP_CLEAR: shadow_count = 0;
			default: res.value = curve_value(k.pos);
		endcase
		res.key_count = shadow_count[4:0];
		return res;
	endfunction

	// valid stays high after acceptance until the next request or release_input
	task automatic send_request(op_e op, key_t k, logic [3:0] idx, bit no_gap = 0);
		int gap;
		curve_result_t res;
		gap = no_gap ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		position <= k.pos;
		seg_start_t <= k.st;
		seg_end_t <= k.et;
		seg_start_v <= k.sv;
		seg_end_v <= k.ev;
		key_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = apply_request(op, k, idx);
		expected_results = {expected_results, res};
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 64)) - 32;
			default: return $urandom;
		endcase
	endfunction

	function automatic key_t rand_key();
		key_t k;
		logic signed [31:0] a, b;
		k.pos = rand_word();
		a = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		b = a + $signed($urandom_range(1, 1 << 18));
		if ($urandom_range(0, 7) == 0) begin
			a = rand_word();
			b = rand_word();
		end
		k.st = a;
		k.et = b;
		k.sv = rand_word();
		k.ev = rand_word();
		if ($urandom_range(0, 3) != 0)
			k.pos = a + $signed($urandom_range(0, 1 << 16));
		return k;
	endfunction

	function automatic key_t query_near();
		key_t k;
		k = '0;
		if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
			k = shadow_keys[$urandom_range(0, shadow_count - 1)];
			k.pos = k.st + $signed($urandom_range(0, 1 << 18)) - 1000;
		end else begin
			k.pos = rand_word();
		end
		return k;
	endfunction

	task automatic wait_drained();
		release_input();
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic test_directed();
		key_t k;
		send_request(OP_EVAL, '0, 4'd0);
		send_request(OP_REMOVE, '0, 4'd0);
		send_request(OP_CLEAR, '0, 4'd0);
		k = '{pos: 32'sh00010000, st: 32'sh00010000, et: 32'sh00030000,
			sv: 32'sh7fffffff, ev: 32'sh80000000};
		send_request(OP_ADD, k, 4'd0);
		send_request(OP_EVAL, '{pos: 32'sh00020000, default: '0}, 4'd0);
		send_request(OP_EVAL, '{pos: 32'sh80000000, default: '0}, 4'd0);
		send_request(OP_EVAL, '{pos: 32'sh7fffffff, default: '0}, 4'd0);
		// equal positions land after existing ones
		k = '{pos: 32'sh00010000, st: 32'sh80000000, et: 32'sh7fffffff,
			sv: 32'sh80000000, ev: 32'sh7fffffff};
		send_request(OP_ADD, k, 4'd15);
		send_request(OP_EVAL, '{pos: 32'sh00010001, default: '0}, 4'd0);
		send_request(OP_EVAL, '{pos: 32'sh00000000, default: '0}, 4'd0);
		// fill to full, then overflow
		for (int i = 0; i < 15; i++)
			send_request(OP_ADD, rand_key(), 4'($urandom));
		send_request(OP_EVAL, query_near(), 4'd0);
		send_request(OP_REMOVE, '0, 4'd15);
		send_request(OP_REMOVE, '0, 4'd0);
		send_request(OP_REMOVE, '0, 4'd15);
		send_request(OP_CLEAR, '1, 4'd0);
	endtask

	task automatic test_random(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				send_request(OP_ADD, rand_key(), 4'($urandom));
			else if (pick < 42)
				send_request(OP_REMOVE, '{pos: $urandom, default: '0}, 4'($urandom));
			else if (pick < 45)
				send_request(OP_CLEAR, rand_key(), 4'($urandom));
			else
				send_request(OP_EVAL, query_near(), 4'($urandom));
		end
	endtask

	task automatic test_backpressure();
		hold_results = 1'b1;
		for (int n = 0; n < 8; n++)
			send_request(OP_EVAL, query_near(), 4'd0, 1);
		release_input();
		wait (!hold_results);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ADD;
		position = '0;
		seg_start_t = '0;
		seg_end_t = '0;
		seg_start_v = '0;
		seg_end_v = '0;
		key_index = '0;
		error_count = 0;
		hold_results = 1'b0;
		shadow_count = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(500);
		wait_drained();
		test_backpressure();
		test_random(550);
		wait_drained();
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off
	initial begin
		int hold;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_results = 1'b0;
			end
			hold = $urandom_range(0, 4);
			if ($urandom_range(0, 3) == 0)
				hold = 0;
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		curve_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result value=%0d status=%0d", value, status);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, value);
					error_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (key_count !== want.key_count) begin
					$error("key_count: expected %0d, got %0d", want.key_count, key_count);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule
